@@ design/rank_fusion_topk_defines.svh @@
// ----------------------------------------------------------------------------
// Rank fusion top-k: assertion macros
// Shared concurrent assertion wrappers clocked on clk.
// ----------------------------------------------------------------------------
`ifndef RANK_FUSION_TOPK_DEFINES_SVH
`define RANK_FUSION_TOPK_DEFINES_SVH

// Checked only while the block is out of reset.
`define RFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rft_pkg.sv @@
// ----------------------------------------------------------------------------
// Rank fusion top-k package
// Codes, states and fixed widths shared by the block's files.
// ----------------------------------------------------------------------------
package rft_pkg;

  localparam int IdW    = 32;
  localparam int ScoreW = 32;
  localparam int RankW  = 16;
  localparam int RrfKW  = 10;
  localparam int TopKW  = 7;
  localparam int DenW   = 17;
  localparam int QuotW  = 25;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 10;

  localparam logic [RrfKW-1:0] RrfKReset = 10'd60;
  localparam logic [TopKW-1:0] TopKReset = 7'd10;

  localparam logic ActHit    = 1'b0;
  localparam logic ActFinish = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgRrfK = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTopK = 1'd1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HSCAN = 6'b000010,
    S_HWAIT = 6'b000100,
    S_HUPD  = 6'b001000,
    S_FSCAN = 6'b010000,
    S_FEMIT = 6'b100000
  } state_t;

endpackage

@@ design/rft_if.sv @@
// ----------------------------------------------------------------------------
// Rank fusion top-k channels
// Valid/ready channels for ranked hits and for fused results.
// ----------------------------------------------------------------------------
interface rft_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [rft_pkg::IdW-1:0] hit_id;
  logic [rft_pkg::RankW-1:0]    hit_rank;

  modport source (output valid, action, hit_id, hit_rank, input ready);
  modport sink   (input valid, action, hit_id, hit_rank, output ready);
endinterface

interface rft_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [rft_pkg::IdW-1:0] result_id;
  logic [rft_pkg::ScoreW-1:0]     result_score;
  logic                           last;

  modport source (output valid, result_id, result_score, last, input ready);
  modport sink   (input valid, result_id, result_score, last, output ready);
endinterface

@@ design/rft_ram.sv @@
// ----------------------------------------------------------------------------
// Rank fusion top-k RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/rft_div.sv @@
// ----------------------------------------------------------------------------
// Rank fusion top-k reciprocal divider
// Restoring divider giving floor(2^24 / denom), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rft_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rft_pkg::DenW-1:0]     denom,
  output logic                         done,
  output logic [rft_pkg::QuotW-1:0]    quot
);

  localparam int CntW = $clog2(rft_pkg::QuotW + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CntW-1:0]             cnt_r, cnt_nxt;
  logic [rft_pkg::DenW-1:0]    den_r, den_nxt;
  logic [rft_pkg::DenW:0]      rem_r, rem_nxt;
  logic [rft_pkg::QuotW-1:0]   sh_r, sh_nxt;
  logic [rft_pkg::DenW:0]      trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    // Remainder stays below denom, so one shifted-in bit fits the extra bit.
    trial    = {rem_r[rft_pkg::DenW-1:0], sh_r[rft_pkg::QuotW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CntW'(rft_pkg::QuotW);
      den_nxt  = denom;
      rem_nxt  = '0;
      sh_nxt   = {1'b1, {(rft_pkg::QuotW-1){1'b0}}};
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        sh_nxt  = {sh_r[rft_pkg::QuotW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        sh_nxt  = {sh_r[rft_pkg::QuotW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign done = done_r;
  assign quot = sh_r;

endmodule

@@ design/rank_fusion_topk.sv @@
// ----------------------------------------------------------------------------
// Rank fusion top-k
// Reciprocal rank fusion of ranked hits into a candidate table, with a sorted
// top-k readout on finish.
// ----------------------------------------------------------------------------
// A hit searches the table one entry per cycle through the RAM read port while a
// bit-serial divider forms the 25-bit reciprocal; the search for an id that is
// already resident stops at its entry. A finish item makes one full pass over
// the table per emitted result; results leave one at a time through an output
// register.
// The table RAM needs no clearing pass; only entries below the count are read.
module rank_fusion_topk #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_TOP     = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rft_in_if.sink                          in_ch,
  rft_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [rft_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [rft_pkg::CfgDataW-1:0]    cfg_wdata
);

`include "rank_fusion_topk_defines.svh"

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int KW = rft_pkg::TopKW;

  rft_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [rft_pkg::RrfKW-1:0]   rrf_k_r, rrf_k_nxt;
  logic [KW-1:0]               top_k_r, top_k_nxt;
  logic [rft_pkg::IdW-1:0]     id_r, id_nxt;
  logic [CW-1:0]               scan_r, scan_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]               chk_idx_r, chk_idx_nxt;
  logic                        found_r, found_nxt;
  logic [AW-1:0]               fidx_r, fidx_nxt;
  logic [KW-1:0]               k_r, k_nxt;
  logic [KW-1:0]               slot_r, slot_nxt;
  logic                        have_r, have_nxt;
  logic [rft_pkg::ScoreW-1:0]  bsc_r, bsc_nxt;
  logic [rft_pkg::IdW-1:0]     bid_r, bid_nxt;
  logic [AW-1:0]               bidx_r, bidx_nxt;
  logic [rft_pkg::ScoreW-1:0]  psc_r, psc_nxt;
  logic [AW-1:0]               pidx_r, pidx_nxt;
  logic                        oval_r, oval_nxt;
  logic [rft_pkg::IdW-1:0]     oid_r, oid_nxt;
  logic [rft_pkg::ScoreW-1:0]  osc_r, osc_nxt;
  logic                        olast_r, olast_nxt;

  logic                        in_xfer, out_xfer;
  logic                        div_start, div_done;
  logic [rft_pkg::DenW-1:0]    denom;
  logic [rft_pkg::QuotW-1:0]   quot;
  logic [rft_pkg::ScoreW-1:0]  contrib;
  logic [rft_pkg::ScoreW:0]    sum;
  logic [AW-1:0]               raddr, waddr;
  logic                        id_we, sc_we;
  logic [rft_pkg::IdW-1:0]     id_wdata, id_rd;
  logic [rft_pkg::ScoreW-1:0]  sc_wdata, sc_rd;
  logic                        elig;
  logic [KW-1:0]               k_clamped;

  assign in_ch.ready = (state_r == rft_pkg::S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = oval_r && out_ch.ready;

  assign out_ch.valid        = oval_r;
  assign out_ch.result_id    = oid_r;
  assign out_ch.result_score = osc_r;
  assign out_ch.last         = olast_r;

  assign denom = rft_pkg::DenW'(rrf_k_r) + rft_pkg::DenW'(in_ch.hit_rank) + 1'b1;
  assign div_start = in_xfer && (in_ch.action == rft_pkg::ActHit) && !in_ch.hit_id[31];
  assign contrib = rft_pkg::ScoreW'(quot);
  assign sum = {1'b0, sc_rd} + {1'b0, contrib};
  assign raddr = (state_r == rft_pkg::S_HWAIT) ? fidx_r : scan_r[AW-1:0];

  always_comb begin
    if (top_k_r == '0) begin
      k_clamped = KW'(1);
    end else if (top_k_r > KW'(MAX_TOP)) begin
      k_clamped = KW'(MAX_TOP);
    end else begin
      k_clamped = top_k_r;
    end
  end

  // Strictly below the previous pick in (score descending, index ascending).
  assign elig = (slot_r == '0) || (sc_rd < psc_r) ||
                ((sc_rd == psc_r) && (chk_idx_r > pidx_r));

  rft_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .denom (denom),
    .done  (div_done),
    .quot  (quot)
  );

  rft_ram #(.WIDTH(rft_pkg::IdW), .DEPTH(TABLE_DEPTH)) u_ids (
    .clk   (clk),
    .we    (id_we),
    .waddr (waddr),
    .wdata (id_wdata),
    .raddr (raddr),
    .rdata (id_rd)
  );

  rft_ram #(.WIDTH(rft_pkg::ScoreW), .DEPTH(TABLE_DEPTH)) u_scores (
    .clk   (clk),
    .we    (sc_we),
    .waddr (waddr),
    .wdata (sc_wdata),
    .raddr (raddr),
    .rdata (sc_rd)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rrf_k_nxt   = rrf_k_r;
    top_k_nxt   = top_k_r;
    id_nxt      = id_r;
    scan_nxt    = scan_r;
    chk_vld_nxt = chk_vld_r;
    chk_idx_nxt = chk_idx_r;
    found_nxt   = found_r;
    fidx_nxt    = fidx_r;
    k_nxt       = k_r;
    slot_nxt    = slot_r;
    have_nxt    = have_r;
    bsc_nxt     = bsc_r;
    bid_nxt     = bid_r;
    bidx_nxt    = bidx_r;
    psc_nxt     = psc_r;
    pidx_nxt    = pidx_r;
    oval_nxt    = oval_r;
    oid_nxt     = oid_r;
    osc_nxt     = osc_r;
    olast_nxt   = olast_r;
    id_we       = 1'b0;
    sc_we       = 1'b0;
    waddr       = cnt_r[AW-1:0];
    id_wdata    = id_r;
    sc_wdata    = contrib;

    if (cfg_we) begin
      case (cfg_index)
        rft_pkg::CfgRrfK: rrf_k_nxt = cfg_wdata[rft_pkg::RrfKW-1:0];
        rft_pkg::CfgTopK: top_k_nxt = cfg_wdata[KW-1:0];
        default: ;
      endcase
    end

    case (state_r)
      rft_pkg::S_IDLE: begin
        if (in_xfer) begin
          id_nxt      = in_ch.hit_id;
          scan_nxt    = '0;
          chk_vld_nxt = 1'b0;
          found_nxt   = 1'b0;
          if (in_ch.action == rft_pkg::ActFinish) begin
            k_nxt     = k_clamped;
            slot_nxt  = '0;
            have_nxt  = 1'b0;
            state_nxt = rft_pkg::S_FSCAN;
          end else if (div_start) begin
            state_nxt = rft_pkg::S_HSCAN;
          end
        end
      end
      rft_pkg::S_HSCAN: begin
        if (chk_vld_r && (id_rd == id_r)) begin
          found_nxt   = 1'b1;
          fidx_nxt    = chk_idx_r;
          chk_vld_nxt = 1'b0;
          state_nxt   = rft_pkg::S_HWAIT;
        end else if (scan_r < cnt_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[AW-1:0];
          scan_nxt    = scan_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            state_nxt = rft_pkg::S_HWAIT;
          end
        end
      end
      rft_pkg::S_HWAIT: begin
        if (div_done) begin
          if (found_r) begin
            state_nxt = rft_pkg::S_HUPD;
          end else begin
            if (cnt_r < CW'(TABLE_DEPTH)) begin
              id_we   = 1'b1;
              sc_we   = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
            state_nxt = rft_pkg::S_IDLE;
          end
        end
      end
      rft_pkg::S_HUPD: begin
        sc_we     = 1'b1;
        waddr     = fidx_r;
        sc_wdata  = sum[rft_pkg::ScoreW] ? '1 : sum[rft_pkg::ScoreW-1:0];
        state_nxt = rft_pkg::S_IDLE;
      end
      rft_pkg::S_FSCAN: begin
        if (chk_vld_r && elig && (!have_r || (sc_rd > bsc_r))) begin
          have_nxt = 1'b1;
          bsc_nxt  = sc_rd;
          bid_nxt  = id_rd;
          bidx_nxt = chk_idx_r;
        end
        if (scan_r < cnt_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[AW-1:0];
          scan_nxt    = scan_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            oval_nxt  = 1'b1;
            oid_nxt   = have_r ? bid_r : '1;
            osc_nxt   = have_r ? bsc_r : '0;
            olast_nxt = (slot_r + 1'b1 == k_r);
            if (have_r) begin
              psc_nxt  = bsc_r;
              pidx_nxt = bidx_r;
            end
            state_nxt = rft_pkg::S_FEMIT;
          end
        end
      end
      rft_pkg::S_FEMIT: begin
        if (out_xfer) begin
          oval_nxt = 1'b0;
          if (olast_r) begin
            cnt_nxt   = '0;
            state_nxt = rft_pkg::S_IDLE;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            scan_nxt  = '0;
            have_nxt  = 1'b0;
            state_nxt = rft_pkg::S_FSCAN;
          end
        end
      end
      default: state_nxt = rft_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rft_pkg::S_IDLE;
      cnt_r     <= '0;
      rrf_k_r   <= rft_pkg::RrfKReset;
      top_k_r   <= rft_pkg::TopKReset;
      chk_vld_r <= 1'b0;
      oval_r    <= 1'b0;
      scan_r    <= '0;
      slot_r    <= '0;
      have_r    <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rrf_k_r   <= rrf_k_nxt;
      top_k_r   <= top_k_nxt;
      chk_vld_r <= chk_vld_nxt;
      oval_r    <= oval_nxt;
      scan_r    <= scan_nxt;
      slot_r    <= slot_nxt;
      have_r    <= have_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    chk_idx_r <= chk_idx_nxt;
    fidx_r    <= fidx_nxt;
    k_r       <= k_nxt;
    bsc_r     <= bsc_nxt;
    bid_r     <= bid_nxt;
    bidx_r    <= bidx_nxt;
    psc_r     <= psc_nxt;
    pidx_r    <= pidx_nxt;
    oid_r     <= oid_nxt;
    osc_r     <= osc_nxt;
    olast_r   <= olast_nxt;
  end

  `RFT_ASSERT(a_out_only_emit, oval_r |-> (state_r == rft_pkg::S_FEMIT), "result shown outside emit")
  `RFT_ASSERT(a_cnt_bound, cnt_r <= CW'(TABLE_DEPTH), "candidate count beyond table depth")
  `RFT_ASSERT(a_last_clears, (out_xfer && olast_r) |=> (cnt_r == '0), "table not emptied after run")
  `RFT_ASSERT(a_finish_scans, (in_xfer && in_ch.action == rft_pkg::ActFinish) |=> (state_r == rft_pkg::S_FSCAN), "finish did not start readout")

endmodule
